### hdl/tgcr_pkg.sv
// tgcr_pkg: shared constants, codes and controller/datapath signal groups
// for the text glyph cursor renderer; no dependencies
package tgcr_pkg;

  localparam int OFS_W      = 24;
  localparam int PITCH_W    = 15;
  localparam int BPP_W      = 3;
  localparam int WIN_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 3;
  localparam int FONT_AW    = CODE_W + ROW_W;
  localparam int DVD_W      = OFS_W + 1;
  localparam int DIV_CNT_W  = 5;

  localparam logic [1:0] OP_DRAW       = 2'd0;
  localparam logic [1:0] OP_FONT_LOAD  = 2'd1;
  localparam logic [1:0] OP_SET_CURSOR = 2'd2;

  localparam logic [CODE_W-1:0] CH_NUL = 8'h00;
  localparam logic [CODE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR  = 8'h0D;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd2;

  localparam logic [PITCH_W-1:0] PITCH_RST  = 15'd4096;
  localparam logic [BPP_W-1:0]   BPP_RST    = 3'd4;
  localparam logic [WIN_W-1:0]   WINDOW_RST = 24'd3145728;

  localparam logic [ROW_W-1:0]     ROW_LAST = 3'd7;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(DVD_W - 1);

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_GLYPH,
    KIND_LF,
    KIND_CR
  } kind_e;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic update;
    logic load_row;
    logic load_single;
  } cmd_t;

  typedef struct packed {
    kind_e in_kind;
    logic  out_free;
    logic  row_last;
  } status_t;

endpackage

### hdl/tgcr_if.sv
// tgcr_if: valid/ready channel interfaces for draw items and glyph row results
// depends on tgcr_pkg for field widths
interface tgcr_item_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [tgcr_pkg::CODE_W-1:0]   char_code;
  logic [tgcr_pkg::ROW_W-1:0]    glyph_row;
  logic [7:0]                    glyph_byte;
  logic [tgcr_pkg::OFS_W-1:0]    start_offset;

  modport source (output valid, op, char_code, glyph_row, glyph_byte, start_offset,
                  input ready);
  modport sink (input valid, op, char_code, glyph_row, glyph_byte, start_offset,
                output ready);
endinterface

interface tgcr_result_if;
  logic                        valid;
  logic                        ready;
  logic                        row_valid;
  logic [tgcr_pkg::OFS_W-1:0]  row_offset;
  logic [7:0]                  row_bits;
  logic [tgcr_pkg::OFS_W-1:0]  cursor_after;
  logic                        last;

  modport source (output valid, row_valid, row_offset, row_bits, cursor_after, last,
                  input ready);
  modport sink (input valid, row_valid, row_offset, row_bits, cursor_after, last,
                output ready);
endinterface

### hdl/tgcr_ctrl.sv
// tgcr_ctrl: sequencer for capture, pitch remainder, cursor update and row output
// depends on tgcr_pkg
module tgcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tgcr_pkg::status_t status_i,
  output tgcr_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_ROWS,
    ST_SINGLE
  } state_e;

  state_e                           state_q, state_d;
  logic [tgcr_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  tgcr_pkg::kind_e                  kind_q, kind_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          kind_d        = status_i.in_kind;
          cnt_d         = '0;
          if (status_i.in_kind == tgcr_pkg::KIND_PLAIN) begin
            state_d = ST_SINGLE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == tgcr_pkg::DIV_LAST) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        if (kind_q == tgcr_pkg::KIND_GLYPH) begin
          state_d = ST_ROWS;
        end else begin
          state_d = ST_SINGLE;
        end
      end
      ST_ROWS: begin
        if (status_i.out_free) begin
          cmd_o.load_row = 1'b1;
          if (status_i.row_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (status_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      kind_q  <= tgcr_pkg::KIND_PLAIN;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
    end
  end

  a_div_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == tgcr_pkg::DIV_LAST) |=> state_q == ST_UPD)
    else $error("remainder pass did not end after the last step");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_row || cmd_o.load_single) |-> status_i.out_free)
    else $error("output register loaded while occupied");

  a_last_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_row && status_i.row_last) |=> state_q == ST_IDLE)
    else $error("row sequence ran past the last glyph row");

endmodule

### hdl/tgcr_dp.sv
// tgcr_dp: config registers, font memory, cursor, restoring remainder unit
// and result register; depends on tgcr_pkg
module tgcr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tgcr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tgcr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [1:0]                        op_i,
  input  logic [tgcr_pkg::CODE_W-1:0]       char_code_i,
  input  logic [tgcr_pkg::ROW_W-1:0]        glyph_row_i,
  input  logic [7:0]                        glyph_byte_i,
  input  logic [tgcr_pkg::OFS_W-1:0]        start_offset_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              row_valid_o,
  output logic [tgcr_pkg::OFS_W-1:0]        row_offset_o,
  output logic [7:0]                        row_bits_o,
  output logic [tgcr_pkg::OFS_W-1:0]        cursor_after_o,
  output logic                              last_o,
  input  tgcr_pkg::cmd_t                    cmd_i,
  output tgcr_pkg::status_t                 status_o
);

  localparam int OW = tgcr_pkg::OFS_W;
  localparam int PW = tgcr_pkg::PITCH_W;
  localparam int DW = tgcr_pkg::DVD_W;

  logic [PW-1:0]                  bpl_q;
  logic [tgcr_pkg::BPP_W-1:0]     bpp_q;
  logic [tgcr_pkg::WIN_W-1:0]     win_q;
  logic [OW-1:0]                  cursor_q, cursor_d;
  logic [tgcr_pkg::CODE_W-1:0]    code_q;
  tgcr_pkg::kind_e                kind_q;
  logic [DW-1:0]                  c_q;
  logic [DW-1:0]                  dvd_q;
  logic [PW-1:0]                  rem_q;
  logic [tgcr_pkg::ROW_W-1:0]     row_q, row_d;
  logic [OW-1:0]                  row_ofs_q;
  logic [7:0]                     rd_q;
  logic [7:0]                     font_mem [2**tgcr_pkg::FONT_AW];

  logic                           out_valid_q;
  logic                           row_valid_q;
  logic [OW-1:0]                  row_offset_q;
  logic [7:0]                     row_bits_q;
  logic [OW-1:0]                  cursor_after_q;
  logic                           last_q;

  logic [PW-1:0]                  pitch;
  logic [DW-1:0]                  c_next;
  logic [PW:0]                    trial;
  logic [PW:0]                    trial_sub;
  logic [PW-1:0]                  rem_next;
  logic [OW-1:0]                  line_base;
  logic [PW+2:0]                  pitch_x8;
  logic [PW+2:0]                  pitch_x7;
  logic [PW+3:0]                  pitch_x15;
  logic [OW:0]                    lf_next;
  logic [DW:0]                    c_plus7;
  logic [DW+1:0]                  c_plus15;
  logic                           out_free;
  tgcr_pkg::kind_e                in_kind;

  assign pitch = (bpl_q == '0) ? PW'(1) : bpl_q;

  always_comb begin
    if (op_i != tgcr_pkg::OP_DRAW) begin
      in_kind = tgcr_pkg::KIND_PLAIN;
    end else if (char_code_i == tgcr_pkg::CH_LF) begin
      in_kind = tgcr_pkg::KIND_LF;
    end else if (char_code_i == tgcr_pkg::CH_CR) begin
      in_kind = tgcr_pkg::KIND_CR;
    end else if (char_code_i == tgcr_pkg::CH_NUL) begin
      in_kind = tgcr_pkg::KIND_PLAIN;
    end else begin
      in_kind = tgcr_pkg::KIND_GLYPH;
    end
  end

  assign c_next = {1'b0, cursor_q} + {{(DW-tgcr_pkg::BPP_W-3){1'b0}}, bpp_q, 3'b000};

  // one restoring step of the pitch remainder
  assign trial     = {rem_q, dvd_q[DW-1]};
  assign trial_sub = trial - {1'b0, pitch};
  assign rem_next  = (trial >= {1'b0, pitch}) ? trial_sub[PW-1:0] : trial[PW-1:0];

  assign line_base = cursor_q - {{(OW-PW){1'b0}}, rem_q};
  assign pitch_x8  = {pitch, 3'b000};
  assign pitch_x7  = pitch_x8 - {3'b000, pitch};
  assign pitch_x15 = {pitch, 4'b0000} - {4'b0000, pitch};
  assign lf_next   = {1'b0, line_base} + {{(OW-PW-2){1'b0}}, pitch_x8};
  assign c_plus7   = {1'b0, c_q} + {{(DW-PW-2){1'b0}}, pitch_x7};
  assign c_plus15  = {2'b00, c_q} + {{(DW-PW-2){1'b0}}, pitch_x15};

  always_comb begin
    cursor_d = cursor_q;
    if (cmd_i.capture && op_i == tgcr_pkg::OP_SET_CURSOR) begin
      cursor_d = start_offset_i;
    end else if (cmd_i.update) begin
      case (kind_q)
        tgcr_pkg::KIND_LF: begin
          cursor_d = (lf_next >= {1'b0, win_q}) ? '0 : lf_next[OW-1:0];
        end
        tgcr_pkg::KIND_CR: begin
          cursor_d = line_base;
        end
        tgcr_pkg::KIND_GLYPH: begin
          if (rem_q != '0) begin
            cursor_d = c_q[OW-1:0];
          end else if (c_plus15 > {3'b000, win_q}) begin
            cursor_d = '0;
          end else begin
            cursor_d = c_plus7[OW-1:0];
          end
        end
        default: begin
          cursor_d = cursor_q;
        end
      endcase
    end
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.update) begin
      row_d = '0;
    end else if (cmd_i.load_row) begin
      row_d = row_q + 1'b1;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpl_q       <= tgcr_pkg::PITCH_RST;
      bpp_q       <= tgcr_pkg::BPP_RST;
      win_q       <= tgcr_pkg::WINDOW_RST;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // indices other than pitch, pixel size and window are ignored
        case (cfg_idx_i)
          tgcr_pkg::REG_PITCH:  bpl_q <= cfg_data_i[PW-1:0];
          tgcr_pkg::REG_BPP:    bpp_q <= cfg_data_i[tgcr_pkg::BPP_W-1:0];
          tgcr_pkg::REG_WINDOW: win_q <= cfg_data_i[tgcr_pkg::WIN_W-1:0];
          default: ;
        endcase
      end
      cursor_q <= cursor_d;
      if (cmd_i.load_row || cmd_i.load_single) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      code_q <= char_code_i;
      kind_q <= in_kind;
      c_q    <= c_next;
      rem_q  <= '0;
      dvd_q  <= (in_kind == tgcr_pkg::KIND_GLYPH) ? c_next : {1'b0, cursor_q};
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
    end
    if (cmd_i.update) begin
      row_ofs_q <= cursor_q;
    end else if (cmd_i.load_row) begin
      row_ofs_q <= row_ofs_q + {{(OW-PW){1'b0}}, pitch};
    end
    row_q <= row_d;
    if (cmd_i.load_row) begin
      row_valid_q    <= 1'b1;
      row_offset_q   <= row_ofs_q;
      row_bits_q     <= rd_q;
      cursor_after_q <= cursor_q;
      last_q         <= (row_q == tgcr_pkg::ROW_LAST);
    end else if (cmd_i.load_single) begin
      row_valid_q    <= 1'b0;
      row_offset_q   <= '0;
      row_bits_q     <= '0;
      cursor_after_q <= cursor_q;
      last_q         <= 1'b1;
    end
  end

  // font store, read address tracks the row about to be shown
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && op_i == tgcr_pkg::OP_FONT_LOAD) begin
      font_mem[{char_code_i, glyph_row_i}] <= glyph_byte_i;
    end
    rd_q <= font_mem[{code_q, row_d}];
  end

  assign out_valid_o    = out_valid_q;
  assign row_valid_o    = row_valid_q;
  assign row_offset_o   = row_offset_q;
  assign row_bits_o     = row_bits_q;
  assign cursor_after_o = cursor_after_q;
  assign last_o         = last_q;

  assign status_o.in_kind  = in_kind;
  assign status_o.out_free = out_free;
  assign status_o.row_last = (row_q == tgcr_pkg::ROW_LAST);

  a_rem_below_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> rem_q < pitch)
    else $error("remainder reached the pitch");

  a_row_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_row |=> out_valid_q && row_valid_q)
    else $error("glyph row not presented after load");

  a_cr_moves_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && kind_q == tgcr_pkg::KIND_CR) |=> cursor_q <= $past(cursor_q))
    else $error("carriage return moved the cursor forward");

endmodule

### hdl/text_glyph_cursor_renderer.sv
// text_glyph_cursor_renderer: top level of the 8x8 character generator
// depends on tgcr_pkg, tgcr_if, tgcr_ctrl and tgcr_dp
//
// Items arrive on item_i (valid/ready). Op 0 draws a character code, op 1
// loads one font byte, op 2 sets the cursor. A drawn glyph gives eight
// transfers on result_o, one per glyph row with its byte offset and mask;
// every other item gives one transfer with row_valid low. cursor_after is
// the cursor once the item is done and last marks the final transfer.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
// Line feed, carriage return and drawn glyphs first run a 25-step restoring
// remainder by the pitch, one bit a cycle; glyph rows then follow one a cycle
// from the registered font memory read while result_o is not stalled.
// The next item is taken as soon as the last result enters the output
// register. A stall on result_o holds that register and the row sequence.
// Reset clears the cursor and loads the default pitch, pixel size and window;
// the font store holds no data until loaded.
module text_glyph_cursor_renderer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tgcr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tgcr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  tgcr_item_if.sink                         item_i,
  tgcr_result_if.source                     result_o
);

  tgcr_pkg::cmd_t    cmd;
  tgcr_pkg::status_t status;

  tgcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tgcr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (item_i.op),
    .char_code_i    (item_i.char_code),
    .glyph_row_i    (item_i.glyph_row),
    .glyph_byte_i   (item_i.glyph_byte),
    .start_offset_i (item_i.start_offset),
    .out_ready_i    (result_o.ready),
    .out_valid_o    (result_o.valid),
    .row_valid_o    (result_o.row_valid),
    .row_offset_o   (result_o.row_offset),
    .row_bits_o     (result_o.row_bits),
    .cursor_after_o (result_o.cursor_after),
    .last_o         (result_o.last),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule
